>>> sv/printf_format_spec_parser_core_macros.svh
// Assertion helpers shared by the parser RTL.
`ifndef PRINTF_FORMAT_SPEC_PARSER_CORE_MACROS_SVH
`define PRINTF_FORMAT_SPEC_PARSER_CORE_MACROS_SVH

// Same-cycle implication, sampled on aclk and held off during reset.
`define PFSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and held off during reset.
`define PFSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/pfsp_pkg.sv
package pfsp_pkg;

    typedef struct packed {
        logic [7:0]         ch;
        logic signed [31:0] star_value;
    } pfsp_in_t;

    typedef struct packed {
        logic [6:0]         spec_char;
        logic [1:0]         length_code;
        logic               plus_set;
        logic               minus_set;
        logic               space_set;
        logic               sharp_set;
        logic               zero_set;
        logic [15:0]        width_digits;
        logic signed [31:0] width_arg;
        logic signed [31:0] precision;
        logic               dot_seen;
    } pfsp_out_t;

    typedef enum logic [1:0] {
        W_NONE   = 2'd0,
        W_DIGITS = 2'd1,
        W_TAKEN  = 2'd2
    } width_phase_t;

    typedef enum logic [1:0] {
        P_NONE   = 2'd0,
        P_DOT    = 2'd1,
        P_DIGITS = 2'd2,
        P_TAKEN  = 2'd3
    } prec_phase_t;

    localparam logic [1:0] LEN_NONE = 2'd0;
    localparam logic [1:0] LEN_H    = 2'd1;
    localparam logic [1:0] LEN_L    = 2'd2;
    localparam logic [1:0] LEN_BIGL = 2'd3;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_SHARP   = 8'h23;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_BIG_L   = 8'h4C;
    localparam logic [7:0] CH_H       = 8'h68;
    localparam logic [7:0] CH_L       = 8'h6C;

    localparam logic [15:0] WIDTH_MAX = 16'hFFFF;
    localparam logic [31:0] PREC_MAX  = 32'h7FFF_FFFF;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_spec(input logic [7:0] c);
        logic r;
        case (c)
            8'h63, 8'h64, 8'h69, 8'h65, 8'h45, 8'h66, 8'h67, 8'h47,
            8'h6F, 8'h73, 8'h75, 8'h78, 8'h58, 8'h70, 8'h6E, CH_PERCENT: begin
                r = 1'b1;
            end
            default: begin
                r = 1'b0;
            end
        endcase
        return r;
    endfunction

endpackage

>>> sv/printf_format_spec_parser_core.sv
// Parses a printf conversion specification one character per cycle, starting
// with the character after the percent sign. Each accepted transfer carries a
// character and the star argument that belongs to it; a specifier letter, a
// percent sign or NUL ends the specification and produces one result transfer
// holding the flags, width, precision, dot and length collected so far. One
// character is taken every cycle while results are being drained; a closing
// character passes through the input register and then through the decode and
// multiply-by-ten update into the result register. The input side stalls only
// when a finished result is still waiting in the result register and the next
// character would end another specification.
module printf_format_spec_parser_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pfsp_pkg::pfsp_in_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output pfsp_pkg::pfsp_out_t m_payload
);
    import pfsp_pkg::*;

    `include "printf_format_spec_parser_core_macros.svh"

    logic          in_valid_reg;
    pfsp_in_t      in_data_reg;
    logic          out_valid_reg;
    pfsp_out_t     out_data_reg;

    logic [4:0]    flag_bits_reg,      flag_bits_next;
    width_phase_t  width_phase_reg,    width_phase_next;
    logic [15:0]   width_acc_reg,      width_acc_next;
    logic [31:0]   width_star_reg,     width_star_next;
    prec_phase_t   prec_phase_reg,     prec_phase_next;
    logic [31:0]   prec_acc_reg,       prec_acc_next;
    logic          dot_flag_reg,       dot_flag_next;
    logic [1:0]    length_reg,         length_next;
    logic          skip_next_reg,      skip_next_next;

    logic          emit;
    logic          done;
    logic          proc_go;
    logic [7:0]    c;
    logic [3:0]    dval;
    logic          c_dig;
    logic [19:0]   width_sum;
    logic [35:0]   prec_sum;

    assign c     = in_data_reg.ch;
    assign dval  = in_data_reg.ch[3:0];
    assign c_dig = is_digit(c);

    // Multiply by ten as two shifts; both sums have room for the carry.
    assign width_sum = ({4'd0, width_acc_reg} << 3) + ({4'd0, width_acc_reg} << 1)
                     + {16'd0, dval};
    assign prec_sum  = ({4'd0, prec_acc_reg} << 3) + ({4'd0, prec_acc_reg} << 1)
                     + {32'd0, dval};

    always_comb begin
        flag_bits_next   = flag_bits_reg;
        width_phase_next = width_phase_reg;
        width_acc_next   = width_acc_reg;
        width_star_next  = width_star_reg;
        prec_phase_next  = prec_phase_reg;
        prec_acc_next    = prec_acc_reg;
        dot_flag_next    = dot_flag_reg;
        length_next      = length_reg;
        skip_next_next   = skip_next_reg;
        emit             = 1'b0;
        done             = 1'b0;

        if (c == CH_NUL) begin
            emit = 1'b1;
        end else begin
            case (prec_phase_reg)
                P_DOT: begin
                    if (c_dig) begin
                        prec_acc_next   = {28'd0, dval};
                        prec_phase_next = P_DIGITS;
                        done            = 1'b1;
                    end else if (c == CH_STAR) begin
                        prec_acc_next   = in_data_reg.star_value;
                        prec_phase_next = P_TAKEN;
                    end else begin
                        prec_acc_next   = '0;
                        prec_phase_next = P_NONE;
                    end
                end
                P_DIGITS: begin
                    if (c_dig) begin
                        prec_acc_next = (prec_sum > {4'd0, PREC_MAX}) ? PREC_MAX
                                                                      : prec_sum[31:0];
                        done          = 1'b1;
                    end else begin
                        prec_phase_next = P_TAKEN;
                    end
                end
                default: begin
                    if (skip_next_reg) begin
                        skip_next_next = 1'b0;
                    end else begin
                        if (width_phase_reg == W_DIGITS) begin
                            if (c_dig) begin
                                width_acc_next = (width_sum > {4'd0, WIDTH_MAX})
                                               ? WIDTH_MAX : width_sum[15:0];
                                done           = 1'b1;
                            end else begin
                                width_phase_next = W_TAKEN;
                            end
                        end
                        if (!done) begin
                            if (c == CH_PLUS) begin
                                flag_bits_next[0] = 1'b1;
                            end else if (c == CH_MINUS) begin
                                flag_bits_next[1] = 1'b1;
                            end else if (c == CH_SPACE) begin
                                flag_bits_next[2] = 1'b1;
                            end else if (c == CH_SHARP) begin
                                flag_bits_next[3] = 1'b1;
                            end else if (c == CH_ZERO && prec_phase_reg == P_NONE
                                         && width_phase_next == W_NONE) begin
                                flag_bits_next[4] = 1'b1;
                            end
                            if (width_phase_next == W_NONE) begin
                                if (c == CH_STAR) begin
                                    width_star_next  = in_data_reg.star_value;
                                    width_phase_next = W_TAKEN;
                                end else if (c_dig) begin
                                    width_acc_next   = {12'd0, dval};
                                    width_phase_next = W_DIGITS;
                                end
                            end
                            if (c == CH_DOT) begin
                                dot_flag_next = 1'b1;
                                if (prec_phase_reg == P_NONE) begin
                                    prec_phase_next = P_DOT;
                                end else begin
                                    skip_next_next = 1'b1;
                                end
                                done = 1'b1;
                            end
                        end
                    end
                end
            endcase

            if (!done) begin
                if (c == CH_H) begin
                    length_next = LEN_H;
                end else if (c == CH_L) begin
                    length_next = LEN_L;
                end else if (c == CH_BIG_L) begin
                    length_next = LEN_BIGL;
                end
                emit = is_spec(c);
            end
        end
    end

    // A character that closes a specification needs the result register free.
    assign proc_go = in_valid_reg && (!emit || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || proc_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_payload;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_bits_reg   <= '0;
            width_phase_reg <= W_NONE;
            width_acc_reg   <= '0;
            width_star_reg  <= '0;
            prec_phase_reg  <= P_NONE;
            prec_acc_reg    <= '0;
            dot_flag_reg    <= 1'b0;
            length_reg      <= LEN_NONE;
            skip_next_reg   <= 1'b0;
        end else if (proc_go) begin
            if (emit) begin
                flag_bits_reg   <= '0;
                width_phase_reg <= W_NONE;
                width_acc_reg   <= '0;
                width_star_reg  <= '0;
                prec_phase_reg  <= P_NONE;
                prec_acc_reg    <= '0;
                dot_flag_reg    <= 1'b0;
                length_reg      <= LEN_NONE;
                skip_next_reg   <= 1'b0;
            end else begin
                flag_bits_reg   <= flag_bits_next;
                width_phase_reg <= width_phase_next;
                width_acc_reg   <= width_acc_next;
                width_star_reg  <= width_star_next;
                prec_phase_reg  <= prec_phase_next;
                prec_acc_reg    <= prec_acc_next;
                dot_flag_reg    <= dot_flag_next;
                length_reg      <= length_next;
                skip_next_reg   <= skip_next_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_go && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_go && emit) begin
            out_data_reg.spec_char    <= c[6:0];
            out_data_reg.length_code  <= length_next;
            out_data_reg.plus_set     <= flag_bits_next[0];
            out_data_reg.minus_set    <= flag_bits_next[1];
            out_data_reg.space_set    <= flag_bits_next[2];
            out_data_reg.sharp_set    <= flag_bits_next[3];
            out_data_reg.zero_set     <= flag_bits_next[4];
            out_data_reg.width_digits <= width_acc_next;
            out_data_reg.width_arg    <= width_star_next;
            out_data_reg.precision    <= prec_acc_next;
            out_data_reg.dot_seen     <= dot_flag_next;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_data_reg;

    `PFSP_ASSERT_NEXT(a_clear_after_emit, proc_go && emit,
        flag_bits_reg == 5'd0 && width_phase_reg == W_NONE && prec_phase_reg == P_NONE,
        "state not cleared after a specification ended")
    `PFSP_ASSERT_NOW(a_prec_needs_dot, prec_phase_reg != P_NONE, dot_flag_reg,
        "precision phase active without a dot")
    `PFSP_ASSERT_NOW(a_skip_after_prec, skip_next_reg, prec_phase_reg == P_TAKEN,
        "skip pending while precision not taken")
    `PFSP_ASSERT_NEXT(a_held_item_kept, in_valid_reg && !proc_go,
        in_valid_reg && $stable(in_data_reg),
        "stalled character lost from the input register")

endmodule

>>> dv/tb_printf_format_spec_parser_core.sv
module tb_printf_format_spec_parser_core;
    import pfsp_pkg::*;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    pfsp_in_t  s_payload;
    logic      m_valid;
    logic      m_ready;
    pfsp_out_t m_payload;

    printf_format_spec_parser_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // Shadow of the parser state, advanced on every accepted input transfer.
    logic [4:0]   flag_acc;
    width_phase_t wid_state;
    logic [15:0]  wid_digits;
    logic [31:0]  wid_star;
    prec_phase_t  prec_state;
    logic [31:0]  prec_value;
    logic         dot_mark;
    logic [1:0]   len_mod;
    logic         skip_one;

    pfsp_out_t pending_specs[$];

    int err_count  = 0;
    int items_sent = 0;
    int idle_pct   = 0;
    int stall_pct  = 0;
    int hold_left  = 0;

    string flag_chars   = " +-#0";
    string spec_letters = "cdieEfgGosuxXpn%";
    string mixed_chars  = "+-# 0123456789*.hlLd%";

    function automatic void clear_spec();
        flag_acc   = '0;
        wid_state  = W_NONE;
        wid_digits = '0;
        wid_star   = '0;
        prec_state = P_NONE;
        prec_value = '0;
        dot_mark   = 1'b0;
        len_mod    = LEN_NONE;
        skip_one   = 1'b0;
    endfunction

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic ends_spec(input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < spec_letters.len(); i++) begin
            if (c == spec_letters[i]) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic void close_spec(input logic [6:0] spec);
        pfsp_out_t res;
        res.spec_char    = spec;
        res.length_code  = len_mod;
        res.plus_set     = flag_acc[0];
        res.minus_set    = flag_acc[1];
        res.space_set    = flag_acc[2];
        res.sharp_set    = flag_acc[3];
        res.zero_set     = flag_acc[4];
        res.width_digits = wid_digits;
        res.width_arg    = wid_star;
        res.precision    = prec_value;
        res.dot_seen     = dot_mark;
        pending_specs.push_back(res);
        clear_spec();
    endfunction

    function automatic void parse_char(input pfsp_in_t item);
        logic [7:0]  c;
        logic [63:0] t;
        logic        tail;
        c    = item.ch;
        tail = 1'b1;
        if (c == CH_NUL) begin
            close_spec(7'd0);
            return;
        end
        if (prec_state == P_DOT) begin
            if (is_dec(c)) begin
                prec_value = {28'd0, c[3:0]};
                prec_state = P_DIGITS;
                tail = 1'b0;
            end else if (c == CH_STAR) begin
                prec_value = item.star_value;
                prec_state = P_TAKEN;
            end else begin
                prec_value = '0;
                prec_state = P_NONE;
            end
        end else if (prec_state == P_DIGITS) begin
            if (is_dec(c)) begin
                t = {32'd0, prec_value} * 64'd10 + {60'd0, c[3:0]};
                prec_value = (t > {32'd0, PREC_MAX}) ? PREC_MAX : t[31:0];
                tail = 1'b0;
            end else begin
                prec_state = P_TAKEN;
            end
        end else if (skip_one) begin
            skip_one = 1'b0;
        end else begin
            if (wid_state == W_DIGITS) begin
                if (is_dec(c)) begin
                    t = {48'd0, wid_digits} * 64'd10 + {60'd0, c[3:0]};
                    wid_digits = (t > {48'd0, WIDTH_MAX}) ? WIDTH_MAX : t[15:0];
                    tail = 1'b0;
                end else begin
                    wid_state = W_TAKEN;
                end
            end
            if (tail) begin
                if (c == CH_PLUS) begin
                    flag_acc[0] = 1'b1;
                end else if (c == CH_MINUS) begin
                    flag_acc[1] = 1'b1;
                end else if (c == CH_SPACE) begin
                    flag_acc[2] = 1'b1;
                end else if (c == CH_SHARP) begin
                    flag_acc[3] = 1'b1;
                end else if (c == CH_ZERO && prec_state == P_NONE && wid_state == W_NONE) begin
                    flag_acc[4] = 1'b1;
                end
                if (wid_state == W_NONE) begin
                    if (c == CH_STAR) begin
                        wid_star  = item.star_value;
                        wid_state = W_TAKEN;
                    end else if (is_dec(c)) begin
                        wid_digits = {12'd0, c[3:0]};
                        wid_state  = W_DIGITS;
                    end
                end
                // A dot after a taken precision only makes the next character skip
                // the flag and width decode.
                if (c == CH_DOT) begin
                    dot_mark = 1'b1;
                    if (prec_state == P_NONE) begin
                        prec_state = P_DOT;
                    end else begin
                        skip_one = 1'b1;
                    end
                    tail = 1'b0;
                end
            end
        end
        if (tail) begin
            if (c == CH_H) begin
                len_mod = LEN_H;
            end else if (c == CH_L) begin
                len_mod = LEN_L;
            end else if (c == CH_BIG_L) begin
                len_mod = LEN_BIGL;
            end
            if (ends_spec(c)) begin
                close_spec(c[6:0]);
            end
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            err_count++;
        end
    endfunction

    // Results are checked before the input of the same edge is predicted; a
    // closing character cannot produce its result in the edge that accepts it.
    always @(posedge aclk) begin
        pfsp_out_t exp_spec;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_specs.size() == 0) begin
                    $display("%0t: unexpected result transfer, got %0h", $time, m_payload);
                    err_count++;
                end else begin
                    exp_spec = pending_specs.pop_front();
                    check_field("spec_char", 32'(exp_spec.spec_char),
                                32'(m_payload.spec_char));
                    check_field("length_code", 32'(exp_spec.length_code),
                                32'(m_payload.length_code));
                    check_field("plus_set", 32'(exp_spec.plus_set),
                                32'(m_payload.plus_set));
                    check_field("minus_set", 32'(exp_spec.minus_set),
                                32'(m_payload.minus_set));
                    check_field("space_set", 32'(exp_spec.space_set),
                                32'(m_payload.space_set));
                    check_field("sharp_set", 32'(exp_spec.sharp_set),
                                32'(m_payload.sharp_set));
                    check_field("zero_set", 32'(exp_spec.zero_set),
                                32'(m_payload.zero_set));
                    check_field("width_digits", 32'(exp_spec.width_digits),
                                32'(m_payload.width_digits));
                    check_field("width_arg", exp_spec.width_arg, m_payload.width_arg);
                    check_field("precision", exp_spec.precision, m_payload.precision);
                    check_field("dot_seen", 32'(exp_spec.dot_seen),
                                32'(m_payload.dot_seen));
                end
            end
            if (s_valid && s_ready) begin
                parse_char(s_payload);
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [31:0] pick_star();
        logic [31:0] v;
        case ($urandom_range(3))
            0: begin
                v = 32'h8000_0000;
            end
            1: begin
                v = 32'h7FFF_FFFF;
            end
            default: begin
                v = $urandom;
            end
        endcase
        return v;
    endfunction

    task automatic send_item(input pfsp_in_t item);
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= item;
        forever begin
            @(posedge aclk);
            if (s_ready) begin
                break;
            end
        end
        items_sent++;
    endtask

    task automatic put_char(input logic [7:0] c);
        pfsp_in_t item;
        item.ch         = c;
        item.star_value = pick_star();
        send_item(item);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) begin
            put_char(txt[i]);
        end
    endtask

    task automatic send_digits(input int n, input logic zero_first);
        put_char(zero_first ? CH_ZERO : 8'(CH_ZERO + $urandom_range(1, 9)));
        repeat (n - 1) begin
            put_char(8'(CH_ZERO + $urandom_range(9)));
        end
    endtask

    // The sender goes quiet first so that the last character is not offered again.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_specs.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    // Mostly well-formed specifications with random content, the rest broken
    // sequences from the meaningful characters and raw byte noise.
    task automatic send_random_spec();
        int kind;
        int n;
        kind = $urandom_range(99);
        if (kind < 75) begin
            n = $urandom_range(4);
            repeat (n) put_char(flag_chars[$urandom_range(4)]);
            case ($urandom_range(2))
                1: begin
                    send_digits($urandom_range(1, 6), $urandom_range(3) == 0);
                end
                2: begin
                    put_char(CH_STAR);
                end
                default: begin
                end
            endcase
            if ($urandom_range(1)) begin
                put_char(CH_DOT);
                case ($urandom_range(3))
                    1, 2: begin
                        send_digits(($urandom_range(9) == 0) ? $urandom_range(10, 11)
                                    : $urandom_range(1, 3), $urandom_range(3) == 0);
                    end
                    3: begin
                        put_char(CH_STAR);
                    end
                    default: begin
                    end
                endcase
                if ($urandom_range(9) == 0) begin
                    put_char(CH_DOT);
                end
            end
            case ($urandom_range(5))
                1: begin
                    put_char(CH_H);
                end
                2: begin
                    put_char(CH_L);
                end
                3: begin
                    put_char(CH_BIG_L);
                end
                4: begin
                    put_char(CH_H);
                    put_char(CH_H);
                end
                5: begin
                    put_char(CH_L);
                    put_char(CH_L);
                end
                default: begin
                end
            endcase
            if ($urandom_range(9) == 0) begin
                put_char(CH_NUL);
            end else begin
                put_char(spec_letters[$urandom_range(15)]);
            end
        end else if (kind < 90) begin
            n = $urandom_range(1, 8);
            repeat (n) put_char(mixed_chars[$urandom_range(mixed_chars.len() - 1)]);
        end else begin
            n = $urandom_range(1, 6);
            repeat (n) put_char(8'($urandom_range(255)));
        end
    endtask

    task automatic test_flags_and_stars();
        pfsp_in_t item;
        send_text("-+ #0");
        item.ch         = CH_STAR;
        item.star_value = 32'h8000_0000;
        send_item(item);
        put_char(CH_DOT);
        item.star_value = 32'h7FFF_FFFF;
        send_item(item);
        send_text("Lf");
    endtask

    // Leading zero is both a flag and the first width digit; a top-bit byte then
    // ends the width run, so the digits after it are not taken and the width stays zero.
    task automatic test_width_saturation();
        put_char(CH_ZERO);
        put_char(8'hFF);
        send_text("70000d");
    endtask

    task automatic test_dot_handling();
        send_text(".h%");
        send_text(".*.l");
        put_char(CH_NUL);
    endtask

    task automatic test_random_specs(input int n, input int idle, input int stall);
        int goal;
        idle_pct  = idle;
        stall_pct = stall;
        goal = items_sent + n;
        while (items_sent < goal) begin
            send_random_spec();
        end
        wait_drained();
    endtask

    // The receiver holds off while short specifications keep arriving, so the
    // result register fills and the input side has to stall.
    task automatic test_output_hold_off();
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = 300;
        repeat (30) begin
            if ($urandom_range(1)) begin
                put_char(8'(CH_ZERO + $urandom_range(1, 9)));
            end
            put_char(spec_letters[$urandom_range(15)]);
        end
        wait_drained();
    endtask

    task automatic test_drain_pause();
        idle_pct  = 11;
        stall_pct = 11;
        repeat (20) begin
            send_random_spec();
            wait_drained();
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_payload = '0;
        m_ready   = 1'b0;
        clear_spec();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_flags_and_stars();
        test_width_saturation();
        test_dot_handling();
        wait_drained();
        test_random_specs(250, 0, 0);
        test_random_specs(250, 80, 0);
        test_random_specs(250, 0, 80);
        test_random_specs(250, 11, 11);
        test_output_hold_off();
        test_drain_pause();

        @(negedge aclk);
        s_valid   <= 1'b0;
        stall_pct = 0;
        wait_drained();
        if (err_count == 0) begin
            $display("printf_format_spec_parser_core regression: pass");
        end else begin
            $display("printf_format_spec_parser_core regression: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("printf_format_spec_parser_core regression: fail");
        $finish;
    end

endmodule
